// ===== rtl/nbt_pkg.sv =====
// Shared types and codes for the neighbor table block.
package nbt_pkg;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_FIND   = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_BADPOS   = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [1:0]         command;
    logic [47:0]        address_in;
    logic [63:0]        uuid_upper;
    logic [63:0]        uuid_lower;
    logic signed [15:0] counter_in;
    logic [5:0]         position_in;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [5:0]         position_out;
    logic [5:0]         entry_id;
    logic signed [15:0] counter_out;
    logic [47:0]        address_out;
    logic [6:0]         count_out;
  } out_t;

  typedef struct packed {
    logic [47:0]        address;
    logic [63:0]        uuid_upper;
    logic [63:0]        uuid_lower;
    logic signed [15:0] counter;
    logic [5:0]         id;
  } entry_t;

  // Which fields a result takes besides status and count.
  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_INSERT,
    SRC_REMOVE,
    SRC_FOUND
  } src_t;

  typedef struct packed {
    logic       latch;
    logic       wr_ins;
    logic       rd_last;
    logic       wr_copy;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       idx_clr;
    logic       scan_en;
    logic       emit_en;
    logic [1:0] emit_status;
    src_t       emit_src;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] command;
    logic       full;
    logic       pos_bad;
    logic       is_last;
    logic       match;
    logic       scan_done;
  } dp_stat_t;

endpackage

// ===== rtl/nbt_ctrl.sv =====
// Command sequencer for the neighbor table.
module nbt_ctrl
  import nbt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_RM_COPY,
    S_FIND
  } state_t;

  state_t state_r, state_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_IDLE;
        case (stat.command)
          CMD_INSERT: begin
            cmd.emit_en = 1'b1;
            if (stat.full) begin
              cmd.emit_status = ST_FULL;
              cmd.emit_src    = SRC_ZERO;
            end else begin
              cmd.wr_ins      = 1'b1;
              cmd.cnt_inc     = 1'b1;
              cmd.emit_status = ST_OK;
              cmd.emit_src    = SRC_INSERT;
            end
          end
          CMD_REMOVE: begin
            if (stat.pos_bad) begin
              cmd.emit_en     = 1'b1;
              cmd.emit_status = ST_BADPOS;
              cmd.emit_src    = SRC_ZERO;
            end else if (stat.is_last) begin
              cmd.cnt_dec     = 1'b1;
              cmd.emit_en     = 1'b1;
              cmd.emit_status = ST_OK;
              cmd.emit_src    = SRC_REMOVE;
            end else begin
              cmd.rd_last = 1'b1;
              state_nxt   = S_RM_COPY;
            end
          end
          CMD_FIND: begin
            cmd.idx_clr = 1'b1;
            state_nxt   = S_FIND;
          end
          default: begin
            cmd.emit_en     = 1'b1;
            cmd.emit_status = ST_BADPOS;
            cmd.emit_src    = SRC_ZERO;
          end
        endcase
      end
      S_RM_COPY: begin
        // The last entry was read in the cycle before; write it over the hole.
        cmd.wr_copy     = 1'b1;
        cmd.cnt_dec     = 1'b1;
        cmd.emit_en     = 1'b1;
        cmd.emit_status = ST_OK;
        cmd.emit_src    = SRC_REMOVE;
        state_nxt       = S_IDLE;
      end
      S_FIND: begin
        cmd.scan_en = 1'b1;
        if (stat.match) begin
          cmd.emit_en     = 1'b1;
          cmd.emit_status = ST_OK;
          cmd.emit_src    = SRC_FOUND;
          state_nxt       = S_IDLE;
        end else if (stat.scan_done) begin
          cmd.emit_en     = 1'b1;
          cmd.emit_status = ST_NOTFOUND;
          cmd.emit_src    = SRC_ZERO;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == S_DECODE))
    else $error("accepted transfer did not reach decode");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RM_COPY) |-> $past(cmd.rd_last))
    else $error("copy without a preceding read of the last entry");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_en |=> (state_r == S_IDLE))
    else $error("sequencer still busy after issuing a result");

endmodule

// ===== rtl/nbt_dp.sv =====
// Datapath of the neighbor table: entry memory, count, scan and result register.
module nbt_dp
  import nbt_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  in_t      in_data,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat,
  output logic     out_strobe,
  output out_t     out_data
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  entry_t mem [CAPACITY];
  entry_t rd_data_r;
  entry_t wr_data;

  in_t              in_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] idx_r;
  logic [IDX_W-1:0] rd_pos_r;
  logic             cmp_vld_r;
  out_t             out_r, out_nxt;
  logic             out_vld_r;

  logic [IDX_W-1:0]   wr_addr, rd_addr, pos_addr, last_addr;
  logic [IDX_W+5:0]   pos_wide_a;
  logic [CNT_W+5:0]   pos_wide_c, count_wide, last_wide;
  logic [CNT_W+6:0]   count7_wide;
  logic [IDX_W+5:0]   rd_pos_wide;
  logic [CNT_W-1:0]   last_cnt;
  logic [5:0]         count6;
  logic               scan_more, rd_en, wr_en;

  assign pos_wide_a  = {{IDX_W{1'b0}}, in_r.position_in};
  assign pos_addr    = pos_wide_a[IDX_W-1:0];
  assign pos_wide_c  = {{CNT_W{1'b0}}, in_r.position_in};
  assign count_wide  = {6'd0, count_r};
  assign last_wide   = count_wide - (CNT_W + 6)'(1);
  assign last_cnt    = count_r - CNT_W'(1);
  assign last_addr   = last_cnt[IDX_W-1:0];
  assign count6      = count_wide[5:0];
  assign count7_wide = {7'd0, count_nxt};
  assign rd_pos_wide = {6'd0, rd_pos_r};
  assign scan_more   = (idx_r < count_r);

  assign stat.command   = in_r.command;
  assign stat.full      = (count_r == CNT_W'(CAPACITY));
  assign stat.pos_bad   = (pos_wide_c >= count_wide);
  assign stat.is_last   = (pos_wide_c == last_wide);
  assign stat.match     = cmp_vld_r
                        && (rd_data_r.uuid_upper == in_r.uuid_upper)
                        && (rd_data_r.uuid_lower == in_r.uuid_lower);
  assign stat.scan_done = !cmp_vld_r && !scan_more;

  assign count_nxt = count_r + CNT_W'(cmd.cnt_inc) - CNT_W'(cmd.cnt_dec);

  // One write port (insert or copy) and one read port (copy source or scan).
  assign wr_en   = cmd.wr_ins || cmd.wr_copy;
  assign wr_addr = cmd.wr_ins ? count_r[IDX_W-1:0] : pos_addr;
  assign rd_en   = cmd.rd_last || (cmd.scan_en && scan_more);
  assign rd_addr = cmd.rd_last ? last_addr : idx_r[IDX_W-1:0];

  always_comb begin
    if (cmd.wr_ins) begin
      wr_data.address    = in_r.address_in;
      wr_data.uuid_upper = in_r.uuid_upper;
      wr_data.uuid_lower = in_r.uuid_lower;
      wr_data.counter    = in_r.counter_in;
      wr_data.id         = count6;
    end else begin
      wr_data = rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    out_nxt           = '0;
    out_nxt.status    = cmd.emit_status;
    out_nxt.count_out = count7_wide[6:0];
    case (cmd.emit_src)
      SRC_INSERT: begin
        out_nxt.position_out = count6;
        out_nxt.entry_id     = count6;
        out_nxt.counter_out  = in_r.counter_in;
        out_nxt.address_out  = in_r.address_in;
      end
      SRC_REMOVE: begin
        out_nxt.position_out = in_r.position_in;
      end
      SRC_FOUND: begin
        out_nxt.position_out = rd_pos_wide[5:0];
        out_nxt.entry_id     = rd_data_r.id;
        out_nxt.counter_out  = rd_data_r.counter;
        out_nxt.address_out  = rd_data_r.address;
      end
      default: begin
        out_nxt.position_out = 6'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      idx_r     <= '0;
      cmp_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      out_vld_r <= cmd.emit_en;
      if (cmd.idx_clr) begin
        idx_r     <= '0;
        cmp_vld_r <= 1'b0;
      end else begin
        cmp_vld_r <= cmd.scan_en && scan_more;
        if (cmd.scan_en && scan_more) begin
          idx_r <= idx_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      in_r <= in_data;
    end
    if (cmd.scan_en && scan_more) begin
      rd_pos_r <= idx_r[IDX_W-1:0];
    end
    if (cmd.emit_en) begin
      out_r <= out_nxt;
    end
  end

  assign out_strobe = out_vld_r;
  assign out_data   = out_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.cnt_inc && cmd.cnt_dec))
    else $error("count raised and lowered in the same cycle");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_ins |-> !stat.full)
    else $error("insert written into a full table");

endmodule

// ===== rtl/neighbor_table_insert_remove_find.sv =====
// Top level of the neighbor table: insert, swap-with-last remove and linear find.
//
//   channel | ports                  | transfer
//   --------+------------------------+--------------------------------------
//   input   | start, busy, in_data   | rising edge with start high, busy low
//   result  | out_strobe, out_data   | every cycle with out_strobe high
//
// Insert ends in decode; remove ends there too on a bad position or the
// last entry, else it copies the last entry over the hole through the single
// read port. Find reads one entry per cycle from the table memory and stops
// at the first match or after the last entry. Reset clears the state, entry
// count, scan index and valid flags, not the table contents. The result is
// strobed for one cycle and cannot be stalled; busy falls as it appears.
module neighbor_table_insert_remove_find
  import nbt_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_strobe,
  output out_t out_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  nbt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  nbt_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_data),
    .cmd        (cmd),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule
